### rtl/cylinder_phi_z_bin_index_core_macros.svh
`ifndef CYLINDER_PHI_Z_BIN_INDEX_CORE_MACROS_SVH
`define CYLINDER_PHI_Z_BIN_INDEX_CORE_MACROS_SVH

// same-cycle implication
`define CPZ_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("cpz assertion failed");

// next-cycle implication
`define CPZ_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cpz assertion failed");

`endif

### rtl/cpz_pkg.sv
`default_nettype none
package cpz_pkg;

  localparam int COORD_BITS    = 20;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int INDEX_BITS    = 12;

  localparam int GUARD_BITS = 16;
  localparam int TURN_BITS  = 32;
  localparam int CW         = COORD_BITS + GUARD_BITS + 3;
  localparam int AW         = TURN_BITS + 2;

  localparam int HL_W  = 19;
  localparam int ZS_W  = 16;
  localparam int BPT_W = 21;
  localparam int CNT_W = 13;
  localparam int CFG_W = 21;
  localparam int CFG_IDX_W = 3;

  localparam int S_W   = ((COORD_BITS > HL_W + 1) ? COORD_BITS : HL_W + 1) + 1;
  localparam int ZB_W  = S_W - 1;
  localparam int ZP_W  = ZB_W + ZS_W;
  localparam int T_W   = ANGLE_BITS + 1;
  localparam int PP_W  = T_W + BPT_W;
  localparam int PHI_W = PP_W - (ANGLE_BITS + 8);

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_TURN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHI_BIN_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_BIN_COUNT   = 3'd4;

  localparam logic signed [AW-1:0] ANG_HALF = 34'sh0_8000_0000;
  localparam logic signed [AW-1:0] ANG_FULL = 34'sh1_0000_0000;

  typedef struct packed {
    logic signed [S_W-1:0] s;
    logic                  y_zero;
    logic                  x_neg;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    side_t                side;
  } cord_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] phi_index;
    logic [INDEX_BITS-1:0] z_index;
    logic                  z_below;
    logic                  z_above;
  } res_t;

  typedef struct packed {
    logic [ZS_W-1:0]       z_scale;
    logic [BPT_W-1:0]      bins_per_turn;
    logic [INDEX_BITS-1:0] phi_limit;
    logic [INDEX_BITS-1:0] z_limit;
  } scale_cfg_t;

  function automatic logic [TURN_BITS-1:0] cpz_atan(logic [4:0] i);
    logic [TURN_BITS-1:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [INDEX_BITS-1:0] cpz_limit(logic [CNT_W-1:0] c);
    logic [INDEX_BITS-1:0] r;
    if (c == '0) begin
      r = '0;
    end else if (32'(c) > (32'd1 << INDEX_BITS)) begin
      r = '1;
    end else begin
      r = INDEX_BITS'(32'(c) - 32'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/cpz_if.sv
`default_nettype none
interface cpz_hit_if;
  import cpz_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface cpz_bin_if;
  import cpz_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] phi_index;
  logic [INDEX_BITS-1:0] z_index;
  logic                  z_below;
  logic                  z_above;

  modport source (output valid, phi_index, z_index, z_below, z_above, input ready);
  modport sink   (input valid, phi_index, z_index, z_below, z_above, output ready);
endinterface
`default_nettype wire

### rtl/cpz_prep.sv
`default_nettype none
module cpz_prep (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 adv,
  input  wire logic                                 in_valid,
  input  wire logic signed [cpz_pkg::COORD_BITS-1:0] pos_x,
  input  wire logic signed [cpz_pkg::COORD_BITS-1:0] pos_y,
  input  wire logic signed [cpz_pkg::COORD_BITS-1:0] pos_z,
  input  wire logic [cpz_pkg::HL_W-1:0]             half_length,
  output cpz_pkg::cord_t                            p,
  output logic                                      p_valid
);
  import cpz_pkg::*;

  cord_t                p_next;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  always_comb begin
    xs = {{(CW-COORD_BITS-GUARD_BITS){pos_x[COORD_BITS-1]}}, pos_x, {GUARD_BITS{1'b0}}};
    ys = {{(CW-COORD_BITS-GUARD_BITS){pos_y[COORD_BITS-1]}}, pos_y, {GUARD_BITS{1'b0}}};
    p_next.side.s = {{(S_W-COORD_BITS){pos_z[COORD_BITS-1]}}, pos_z}
                  + {{(S_W-HL_W){1'b0}}, half_length};
    p_next.side.y_zero = (pos_y == '0);
    p_next.side.x_neg  = pos_x[COORD_BITS-1];
    if (pos_x[COORD_BITS-1]) begin
      p_next.x   = -xs;
      p_next.y   = -ys;
      p_next.ang = (!pos_y[COORD_BITS-1] && pos_y != '0) ? ANG_HALF : -ANG_HALF;
    end else begin
      p_next.x   = xs;
      p_next.y   = ys;
      p_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= in_valid;
      p       <= p_next;
    end
  end

endmodule
`default_nettype wire

### rtl/cpz_cordic.sv
`default_nettype none
module cpz_cordic (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire cpz_pkg::cord_t p,
  input  wire logic           p_valid,
  output cpz_pkg::cord_t      q,
  output logic                q_valid
);
  import cpz_pkg::*;

  cord_t stg [CORDIC_STAGES];
  logic  vld [CORDIC_STAGES];

  function automatic cord_t cpz_iter(cord_t c, int sh);
    cord_t                r;
    logic signed [AW-1:0] da;
    da = $signed({{(AW-TURN_BITS){1'b0}}, cpz_atan(5'(sh))});
    r  = c;
    if (c.y > 0) begin
      r.x   = c.x + (c.y >>> sh);
      r.y   = c.y - (c.x >>> sh);
      r.ang = c.ang + da;
    end else begin
      r.x   = c.x - (c.y >>> sh);
      r.y   = c.y + (c.x >>> sh);
      r.ang = c.ang - da;
    end
    return r;
  endfunction

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (adv) begin
          vld[i] <= p_valid;
          stg[i] <= cpz_iter(p, i);
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (adv) begin
          vld[i] <= vld[i-1];
          stg[i] <= cpz_iter(stg[i-1], i);
        end
      end
    end
  end

  assign q       = stg[CORDIC_STAGES-1];
  assign q_valid = vld[CORDIC_STAGES-1];

endmodule
`default_nettype wire

### rtl/cpz_scale.sv
`default_nettype none
module cpz_scale (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire cpz_pkg::cord_t      q,
  input  wire logic                q_valid,
  input  wire cpz_pkg::scale_cfg_t cfg,
  output cpz_pkg::res_t            res,
  output logic                     res_valid
);
  import cpz_pkg::*;

  `include "cylinder_phi_z_bin_index_core_macros.svh"

  logic signed [AW-1:0] ang_off;
  logic [TURN_BITS:0]   u;
  logic [T_W-1:0]       t;
  logic [ZB_W-1:0]      zb;
  logic [PHI_W-1:0]     phi;

  logic                 a_valid;
  logic [T_W-1:0]       a_t;
  logic [ZP_W-1:0]      a_zprod;
  logic                 a_below;

  logic                 b_valid;
  logic [PP_W-1:0]      b_phip;
  logic [INDEX_BITS-1:0] b_zi;
  logic                 b_below;
  logic                 b_above;

  always_comb begin
    ang_off = q.ang + ANG_HALF;
    priority if (q.side.y_zero) begin
      u = q.side.x_neg ? (TURN_BITS+1)'(ANG_FULL) : (TURN_BITS+1)'(ANG_HALF);
    end else if (ang_off < 0) begin
      u = '0;
    end else if (ang_off > ANG_FULL) begin
      u = (TURN_BITS+1)'(ANG_FULL);
    end else begin
      u = ang_off[TURN_BITS:0];
    end
    t = u[TURN_BITS:TURN_BITS-ANGLE_BITS];
  end

  always_comb begin
    zb  = a_zprod[ZP_W-1:ZS_W];
    phi = b_phip[PP_W-1:ANGLE_BITS+8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= q_valid;
      a_t       <= t;
      a_zprod   <= q.side.s[ZB_W-1:0] * cfg.z_scale;
      a_below   <= q.side.s[S_W-1];

      b_valid   <= a_valid;
      b_phip    <= a_t * cfg.bins_per_turn;
      b_below   <= a_below;
      priority if (a_below) begin
        b_zi    <= '0;
        b_above <= 1'b0;
      end else if (64'(zb) > 64'(cfg.z_limit)) begin
        b_zi    <= cfg.z_limit;
        b_above <= 1'b1;
      end else begin
        b_zi    <= INDEX_BITS'(zb);
        b_above <= 1'b0;
      end

      res_valid     <= b_valid;
      res.z_index   <= b_zi;
      res.z_below   <= b_below;
      res.z_above   <= b_above;
      res.phi_index <= (64'(phi) > 64'(cfg.phi_limit)) ? cfg.phi_limit : INDEX_BITS'(phi);
    end
  end

  `CPZ_ASSERT_NXT(a_advance_out, clk, rst, b_valid && adv, res_valid)
  `CPZ_ASSERT_NXT(a_advance_mid, clk, rst, a_valid && adv, b_valid)

endmodule
`default_nettype wire

### rtl/cylinder_phi_z_bin_index_core.sv
// channel | role          | beat payload
// --------+---------------+------------------------------------------
// hit     | sink          | pos_x, pos_y, pos_z (signed, 1/1024 cm)
// bin     | source        | phi_index, z_index, z_below, z_above
// wr_*    | register port | wr_en, wr_index, wr_data (no read-back)
//
// One beat enters per cycle unless the output is held; stages are one prep stage,
// one per CORDIC iteration (16), three scale stages (clamp, multiply, saturate).
// rst is synchronous and clears all valid bits and the registers to defaults.
// A held output beat freezes the whole pipeline; hit.ready drops that cycle.
`default_nettype none
module cylinder_phi_z_bin_index_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  cpz_hit_if.sink                              hit,
  cpz_bin_if.source                            bin,
  input  wire logic                            wr_en,
  input  wire logic [cpz_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [cpz_pkg::CFG_W-1:0]       wr_data
);
  import cpz_pkg::*;

  `include "cylinder_phi_z_bin_index_core_macros.svh"

  logic [HL_W-1:0]  half_length;
  logic [ZS_W-1:0]  z_scale;
  logic [BPT_W-1:0] bins_per_turn;
  logic [CNT_W-1:0] phi_bin_count;
  logic [CNT_W-1:0] z_bin_count;

  logic       adv;
  cord_t      p;
  logic       p_valid;
  cord_t      q;
  logic       q_valid;
  scale_cfg_t scfg;
  res_t       res;
  logic       res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length   <= '0;
      z_scale       <= '0;
      bins_per_turn <= '0;
      phi_bin_count <= CNT_W'(1);
      z_bin_count   <= CNT_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_HALF_LENGTH:   half_length   <= wr_data[HL_W-1:0];
        CFG_Z_SCALE:       z_scale       <= wr_data[ZS_W-1:0];
        CFG_BINS_PER_TURN: bins_per_turn <= wr_data[BPT_W-1:0];
        CFG_PHI_BIN_COUNT: phi_bin_count <= wr_data[CNT_W-1:0];
        CFG_Z_BIN_COUNT:   z_bin_count   <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !res_valid || bin.ready;
  assign hit.ready = adv;

  assign scfg.z_scale       = z_scale;
  assign scfg.bins_per_turn = bins_per_turn;
  assign scfg.phi_limit     = cpz_limit(phi_bin_count);
  assign scfg.z_limit       = cpz_limit(z_bin_count);

  cpz_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (hit.valid),
    .pos_x       (hit.pos_x),
    .pos_y       (hit.pos_y),
    .pos_z       (hit.pos_z),
    .half_length (half_length),
    .p           (p),
    .p_valid     (p_valid)
  );

  cpz_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .p       (p),
    .p_valid (p_valid),
    .q       (q),
    .q_valid (q_valid)
  );

  cpz_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .q         (q),
    .q_valid   (q_valid),
    .cfg       (scfg),
    .res       (res),
    .res_valid (res_valid)
  );

  assign bin.valid     = res_valid;
  assign bin.phi_index = res.phi_index;
  assign bin.z_index   = res.z_index;
  assign bin.z_below   = res.z_below;
  assign bin.z_above   = res.z_above;

  `CPZ_ASSERT_IMP(a_below_zero, clk, rst, bin.valid && bin.z_below, bin.z_index == '0)
  `CPZ_ASSERT_IMP(a_flags_excl, clk, rst, bin.valid, !(bin.z_below && bin.z_above))
  `CPZ_ASSERT_IMP(a_stall_cause, clk, rst, !hit.ready, bin.valid && !bin.ready)

endmodule
`default_nettype wire

### verif/tb_cylinder_phi_z_bin_index_core.sv
`timescale 1ns / 1ps
module tb_cylinder_phi_z_bin_index_core;
  import cpz_pkg::*;

  localparam int LATENCY          = 20;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DEFAULT_HITS     = 40;
  localparam int HITS_PER_SETTING = 180;
  localparam int LAST_SETTING     = 7;
  localparam int MAX_GAP          = 18;
  localparam int REPORT_CAP       = 100;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));
  localparam longint HALF_TURN = longint'(1) <<< (TURN_BITS - 1);
  localparam longint FULL_TURN = longint'(1) <<< TURN_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   typed;
    res_t   want;
  } probe_t;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TURN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // run under half_length 1024, z_scale 65535, one bin per 2^-12 turn, 4096 bins each
  localparam probe_t PROBES [24] = '{
    '{0,         0,         -1025,     1'b1, '{12'd2048, 12'd0,    1'b1, 1'b0}},
    '{COORD_MIN, 0,         COORD_MAX, 1'b1, '{12'd4095, 12'd4095, 1'b0, 1'b1}},
    '{COORD_MAX, 0,         -1024,     1'b1, '{12'd2048, 12'd0,    1'b0, 1'b0}},
    '{1,         0,         -1023,     1'b1, '{12'd2048, 12'd0,    1'b0, 1'b0}},
    '{-1,        0,         3071,      1'b1, '{12'd4095, 12'd4094, 1'b0, 1'b0}},
    '{5,         0,         3072,      1'b1, '{12'd2048, 12'd4095, 1'b0, 1'b0}},
    '{-5,        0,         3073,      1'b1, '{12'd4095, 12'd4095, 1'b0, 1'b1}},
    '{0,         0,         COORD_MIN, 1'b1, '{12'd2048, 12'd0,    1'b1, 1'b0}},
    '{0,         COORD_MAX, 0,         1'b0, '0},
    '{0,         COORD_MIN, 0,         1'b0, '0},
    '{0,         1,         -1,        1'b0, '0},
    '{0,         -1,        1,         1'b0, '0},
    '{COORD_MAX, COORD_MAX, 100,       1'b0, '0},
    '{COORD_MIN, COORD_MIN, -100,      1'b0, '0},
    '{COORD_MIN, COORD_MAX, 200000,    1'b0, '0},
    '{COORD_MAX, COORD_MIN, -200000,   1'b0, '0},
    '{COORD_MIN, 1,         1,         1'b0, '0},
    '{COORD_MIN, -1,        -1,        1'b0, '0},
    '{1,         1,         0,         1'b0, '0},
    '{-1,        -1,        0,         1'b0, '0},
    '{-1,        1,         2,         1'b0, '0},
    '{1,         -1,        3,         1'b0, '0},
    '{3000,      -4000,     500,       1'b0, '0},
    '{-77777,    12345,     -777,      1'b0, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  cpz_hit_if hit_ch ();
  cpz_bin_if bin_ch ();

  cylinder_phi_z_bin_index_core DUT (
    .clk      (clk),
    .rst      (rst),
    .hit      (hit_ch),
    .bin      (bin_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  longint cfg_half_length;
  longint cfg_z_scale;
  longint cfg_bins_per_turn;
  longint cfg_phi_bin_count;
  longint cfg_z_bin_count;

  res_t   bins_due [$];
  logic   hit_typed;
  res_t   hit_want;
  int     send_gap_max;
  int     recv_gap_max;
  int     mismatches    = 0;
  int     hits_taken    = 0;
  int     bins_checked  = 0;
  int     settings_used = 0;
  int     cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint lim_of(longint count);
    if (count == 0) return 0;
    if (count > (longint'(1) <<< INDEX_BITS)) return (longint'(1) <<< INDEX_BITS) - 1;
    return count - 1;
  endfunction

  function automatic res_t predict_bins(coord_t x, coord_t y, coord_t z);
    longint cx, cy, nx, ny, ang, u, t, phi, s, zb;
    res_t   r;
    int     i;
    r  = '0;
    cx = longint'(x);
    cy = longint'(y);
    if (cy == 0) begin
      u = (cx < 0) ? FULL_TURN : HALF_TURN;
    end else begin
      cx  = cx <<< GUARD_BITS;
      cy  = cy <<< GUARD_BITS;
      ang = 0;
      if (cx < 0) begin
        ang = (cy > 0) ? HALF_TURN : -HALF_TURN;
        cx  = -cx;
        cy  = -cy;
      end
      for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        if (cy > 0) begin
          nx  = cx + (cy >>> i);
          ny  = cy - (cx >>> i);
          ang = ang + longint'(ATAN_TURN[i]);
        end else begin
          nx  = cx - (cy >>> i);
          ny  = cy + (cx >>> i);
          ang = ang - longint'(ATAN_TURN[i]);
        end
        cx = nx;
        cy = ny;
      end
      ang = ang + HALF_TURN;
      u   = (ang < 0) ? 0 : ((ang > FULL_TURN) ? FULL_TURN : ang);
    end
    t   = u >>> (TURN_BITS - ANGLE_BITS);
    phi = (t * cfg_bins_per_turn) >>> (ANGLE_BITS + 8);
    if (phi > lim_of(cfg_phi_bin_count)) phi = lim_of(cfg_phi_bin_count);
    r.phi_index = phi[INDEX_BITS-1:0];
    s = longint'(z) + cfg_half_length;
    if (s < 0) begin
      r.z_below = 1'b1;
    end else begin
      zb = (s * cfg_z_scale) >>> ZS_W;
      if (zb > lim_of(cfg_z_bin_count)) begin
        zb        = lim_of(cfg_z_bin_count);
        r.z_above = 1'b1;
      end
      r.z_index = zb[INDEX_BITS-1:0];
    end
    return r;
  endfunction

  function automatic coord_t to_coord(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic int draw_gap(int max_gap);
    if (max_gap == 0 || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("MISMATCH %s at bin beat %0d: got %0d, want %0d", what, bins_checked, got, want);
  endtask

  task automatic write_cfg(longint hl, longint zs, longint bpt, longint pbc, longint zbc);
    logic [CFG_IDX_W-1:0] idx [6];
    longint               val [6];
    int                   k;
    idx = '{CFG_HALF_LENGTH, CFG_Z_SCALE, CFG_BINS_PER_TURN,
            CFG_PHI_BIN_COUNT, CFG_Z_BIN_COUNT, CFG_SPARE};
    val = '{hl, zs, bpt, pbc, zbc, longint'($urandom)};
    for (k = 0; k < 6; k++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[k];
      wr_data  <= CFG_W'(val[k]);
      case (idx[k])
        CFG_HALF_LENGTH:   cfg_half_length   = val[k] & ((longint'(1) <<< HL_W) - 1);
        CFG_Z_SCALE:       cfg_z_scale       = val[k] & ((longint'(1) <<< ZS_W) - 1);
        CFG_BINS_PER_TURN: cfg_bins_per_turn = val[k] & ((longint'(1) <<< BPT_W) - 1);
        CFG_PHI_BIN_COUNT: cfg_phi_bin_count = val[k] & ((longint'(1) <<< CNT_W) - 1);
        CFG_Z_BIN_COUNT:   cfg_z_bin_count   = val[k] & ((longint'(1) <<< CNT_W) - 1);
        default: ;
      endcase
      @(posedge clk);
    end
    wr_en <= 1'b0;
    settings_used++;
  endtask

  // hold the sender until every bin beat is back, then let the pipeline settle
  task automatic wait_drained();
    hit_ch.valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic send_hit(coord_t x, coord_t y, coord_t z, logic typed, res_t want);
    int   gap;
    logic took;
    gap = draw_gap(send_gap_max);
    if (gap > 0) begin
      hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_typed = typed;
    hit_want  = want;
    hit_ch.valid <= 1'b1;
    hit_ch.pos_x <= x;
    hit_ch.pos_y <= y;
    hit_ch.pos_z <= z;
    do begin
      @(negedge clk);
      took = hit_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic make_hit(output coord_t x, output coord_t y, output coord_t z);
    longint z_edge;
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    z = coord_t'($urandom);
    case ($urandom_range(0, 7))
      3: begin
        if ($urandom_range(0, 1) != 0) y = '0;
        else x = '0;
      end
      4: begin
        x = to_coord(int'($urandom_range(0, 64)) - 32);
        y = to_coord(int'($urandom_range(0, 64)) - 32);
        z = to_coord(int'($urandom_range(0, 64)) - 32);
      end
      5: z = to_coord(-cfg_half_length + int'($urandom_range(0, 8)) - 4);
      6: begin
        if (cfg_z_scale != 0) begin
          z_edge = ((lim_of(cfg_z_bin_count) + 1) * 65536 + cfg_z_scale - 1) / cfg_z_scale
                   - cfg_half_length;
          z = to_coord(z_edge + int'($urandom_range(0, 6)) - 3);
        end
      end
      7: y = ($urandom_range(0, 1) != 0) ? x : -x;
      default: ;
    endcase
  endtask

  task automatic run_random(int count);
    coord_t x, y, z;
    int     k;
    for (k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained();
      make_hit(x, y, z);
      send_hit(x, y, z, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin : watch
    res_t want;
    if (!rst) begin
      if (hit_ch.valid && hit_ch.ready) begin
        bins_due.push_back(hit_typed ? hit_want
                                     : predict_bins(hit_ch.pos_x, hit_ch.pos_y, hit_ch.pos_z));
        hits_taken++;
      end
      if (bin_ch.valid && bin_ch.ready) begin
        if (bins_due.size() == 0) begin
          report_mismatch("bin beat with nothing pending, phi_index", bin_ch.phi_index, 0);
        end else begin
          want = bins_due.pop_front();
          if (bin_ch.phi_index !== want.phi_index)
            report_mismatch("phi_index", bin_ch.phi_index, want.phi_index);
          if (bin_ch.z_index !== want.z_index)
            report_mismatch("z_index", bin_ch.z_index, want.z_index);
          if (bin_ch.z_below !== want.z_below)
            report_mismatch("z_below", bin_ch.z_below, want.z_below);
          if (bin_ch.z_above !== want.z_above)
            report_mismatch("z_above", bin_ch.z_above, want.z_above);
        end
        bins_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_cylinder_phi_z_bin_index_core: done, errors");
      $finish;
    end
  end

  initial begin : drain_side
    int   gap;
    logic took;
    bin_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_gap_max);
      if (gap > 0) begin
        bin_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      bin_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = bin_ch.valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin : stimulus
    int k;
    int p;
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = '0;
    wr_data           = '0;
    hit_ch.valid      = 1'b0;
    hit_ch.pos_x      = '0;
    hit_ch.pos_y      = '0;
    hit_ch.pos_z      = '0;
    hit_typed         = 1'b0;
    hit_want          = '0;
    send_gap_max      = MAX_GAP;
    recv_gap_max      = MAX_GAP;
    cfg_half_length   = 0;
    cfg_z_scale       = 0;
    cfg_bins_per_turn = 0;
    cfg_phi_bin_count = 1;
    cfg_z_bin_count   = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    settings_used = 1;
    run_random(DEFAULT_HITS);
    wait_drained();

    write_cfg(1024, 65535, 1048576, 4096, 4096);
    for (k = 0; k < 24; k++)
      send_hit(PROBES[k].x, PROBES[k].y, PROBES[k].z, PROBES[k].typed, PROBES[k].want);
    wait_drained();

    for (p = 1; p <= LAST_SETTING; p++) begin
      case (p)
        1: write_cfg(204800, 655, 1048576, 4096, 4096);
        2: write_cfg(2**HL_W - 1, 2**ZS_W - 1, 2**BPT_W - 1, 2**CNT_W - 1, 2**CNT_W - 1);
        3: write_cfg(0, 0, 0, 0, 0);
        4: write_cfg(5000, 1000, 9216, 17, 9);
        5: write_cfg($urandom_range(0, 2**CFG_W - 1), $urandom_range(0, 2**CFG_W - 1),
                     $urandom_range(0, 2**CFG_W - 1), $urandom_range(0, 2**CFG_W - 1),
                     $urandom_range(0, 2**CFG_W - 1));
        6: write_cfg($urandom_range(0, 2**HL_W - 1), $urandom_range(0, 2**ZS_W - 1),
                     $urandom_range(0, 1048576), $urandom_range(1, 4096),
                     $urandom_range(1, 4096));
        default: write_cfg($urandom_range(0, 2**HL_W - 1), $urandom_range(0, 2**ZS_W - 1),
                           $urandom_range(0, 1048576), $urandom_range(1, 64),
                           $urandom_range(1, 64));
      endcase
      send_gap_max = (p % 2 == 1) ? MAX_GAP : 0;
      recv_gap_max = ((p / 2) % 2 == 1) ? MAX_GAP : 0;
      run_random(HITS_PER_SETTING);
      wait_drained();
    end

    $display("hits accepted: %0d, bin beats compared: %0d, mismatches: %0d",
             hits_taken, bins_checked, mismatches);
    $display("register settings: %0d (reset values, zero and full-scale, small and random)",
             settings_used);
    if (mismatches == 0) begin
      $display("tb_cylinder_phi_z_bin_index_core: done, clean");
    end else begin
      $display("tb_cylinder_phi_z_bin_index_core: done, errors");
    end
    $finish;
  end

endmodule
